@@ src/pipeline_cpu_control_unit_assert.svh @@
// assertion macros for the decode control block
// used by pipeline_cpu_control_unit.sv, needs no other file
`ifndef PIPELINE_CPU_CONTROL_UNIT_ASSERT_SVH
`define PIPELINE_CPU_CONTROL_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PCU_ASSERT_IMP(name, ck, rstn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PCU_ASSERT_NXT(name, ck, rstn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/pcu_pkg.sv @@
// shared types and constants of the decode control block
// no dependencies
`default_nettype none

package pcu_pkg;

    localparam int REG_W = 5;
    localparam int OP_W  = 6;
    localparam int NUM_OPS = 16;

    typedef enum logic [3:0] {
        OP_AND    = 4'd0,
        OP_ANDI   = 4'd1,
        OP_OR     = 4'd2,
        OP_ORI    = 4'd3,
        OP_ADD    = 4'd4,
        OP_ADDI   = 4'd5,
        OP_SUB    = 4'd6,
        OP_SUBI   = 4'd7,
        OP_LOAD   = 4'd8,
        OP_STORE  = 4'd9,
        OP_BNE    = 4'd10,
        OP_BEQ    = 4'd11,
        OP_BRANCH = 4'd12,
        OP_SLL    = 4'd13,
        OP_SRL    = 4'd14,
        OP_SRA    = 4'd15
    } opcode_e;

    // operand select codes
    localparam logic [1:0] FWD_REG = 2'd0;
    localparam logic [1:0] FWD_IMM = 2'd1;
    localparam logic [1:0] FWD_EX  = 2'd2;
    localparam logic [1:0] FWD_MEM = 2'd3;

    // one flag per instruction class, at most one set
    typedef struct packed {
        logic i_and;
        logic i_andi;
        logic i_or;
        logic i_ori;
        logic i_add;
        logic i_addi;
        logic i_sub;
        logic i_subi;
        logic i_load;
        logic i_store;
        logic i_bne;
        logic i_beq;
        logic i_br;
        logic i_sll;
        logic i_srl;
        logic i_sra;
    } class_t;

    typedef struct packed {
        logic             is_store;
        logic [REG_W-1:0] second_reg;
        logic [1:0]       fwd_a;
        logic [1:0]       fwd_b;
        logic             no_stall;
        logic [3:0]       alu_code;
        logic             sign_extend;
        logic             write_zero_flag;
        logic             write_reg;
        logic             write_mem;
        logic             mem_to_reg;
        logic             pc_select;
    } result_t;

endpackage

`default_nettype wire

@@ src/pcu_decode.sv @@
// opcode decoder: instruction classes from opcode and word-valid flag
// depends on pcu_pkg
`default_nettype none

module pcu_decode (
    input  wire logic [pcu_pkg::OP_W-1:0] opcode,
    input  wire logic                     inst_valid,
    output pcu_pkg::class_t               cls
);

    logic [pcu_pkg::NUM_OPS-1:0] hot;

    // undefined opcodes and empty words decode to no class
    always_comb
    begin
        hot = '0;
        if (inst_valid && (opcode[pcu_pkg::OP_W-1:4] == '0))
        begin
            hot[opcode[3:0]] = 1'b1;
        end
    end

    assign cls.i_and   = hot[pcu_pkg::OP_AND];
    assign cls.i_andi  = hot[pcu_pkg::OP_ANDI];
    assign cls.i_or    = hot[pcu_pkg::OP_OR];
    assign cls.i_ori   = hot[pcu_pkg::OP_ORI];
    assign cls.i_add   = hot[pcu_pkg::OP_ADD];
    assign cls.i_addi  = hot[pcu_pkg::OP_ADDI];
    assign cls.i_sub   = hot[pcu_pkg::OP_SUB];
    assign cls.i_subi  = hot[pcu_pkg::OP_SUBI];
    assign cls.i_load  = hot[pcu_pkg::OP_LOAD];
    assign cls.i_store = hot[pcu_pkg::OP_STORE];
    assign cls.i_bne   = hot[pcu_pkg::OP_BNE];
    assign cls.i_beq   = hot[pcu_pkg::OP_BEQ];
    assign cls.i_br    = hot[pcu_pkg::OP_BRANCH];
    assign cls.i_sll   = hot[pcu_pkg::OP_SLL];
    assign cls.i_srl   = hot[pcu_pkg::OP_SRL];
    assign cls.i_sra   = hot[pcu_pkg::OP_SRA];

endmodule

`default_nettype wire

@@ src/pcu_ctrl.sv @@
// forwarding, hazard detection and control signal generation
// depends on pcu_pkg
`default_nettype none

module pcu_ctrl (
    input  wire pcu_pkg::class_t            cls,
    input  wire logic [pcu_pkg::REG_W-1:0]  src1_reg,
    input  wire logic [pcu_pkg::REG_W-1:0]  dest_reg,
    input  wire logic [pcu_pkg::REG_W-1:0]  src2_reg,
    input  wire logic [pcu_pkg::REG_W-1:0]  ex_dest,
    input  wire logic                       ex_writes_reg,
    input  wire logic                       ex_is_load,
    input  wire logic                       mem_zero,
    input  wire logic [pcu_pkg::REG_W-1:0]  mem_dest,
    input  wire logic                       mem_writes_reg,
    input  wire logic                       ex_pc_taken,
    output pcu_pkg::result_t                res
);

    logic [pcu_pkg::REG_W-1:0] rnb;
    logic a_reg, b_reg, a_ex, a_mem, b_ex, b_mem;
    logic hazard, nost, go, shifts;

    assign rnb = cls.i_store ? dest_reg : src2_reg;

    assign a_reg = cls.i_and | cls.i_andi | cls.i_or | cls.i_ori | cls.i_add | cls.i_addi
                 | cls.i_sub | cls.i_subi | cls.i_load | cls.i_store;
    assign b_reg = cls.i_and | cls.i_or | cls.i_add | cls.i_sub;

    // execute stage has priority over memory stage
    assign a_ex  = a_reg && ex_writes_reg && (src1_reg == ex_dest);
    assign a_mem = a_reg && !a_ex && mem_writes_reg && (src1_reg == mem_dest);
    assign b_ex  = b_reg && ex_writes_reg && (rnb == ex_dest);
    assign b_mem = b_reg && !b_ex && mem_writes_reg && (rnb == mem_dest);

    // load-use and compare-branch-after-alu hazards
    assign hazard = (a_reg && (src1_reg == ex_dest) && ex_is_load)
                 || (b_reg && (rnb == ex_dest) && ex_is_load)
                 || (cls.i_store && (dest_reg == ex_dest) && ex_is_load)
                 || ((cls.i_bne | cls.i_beq) && ex_writes_reg && !ex_is_load);
    assign nost   = !hazard;
    assign go     = nost && !ex_pc_taken;
    assign shifts = cls.i_sll | cls.i_srl | cls.i_sra;

    always_comb
    begin
        res.is_store   = cls.i_store;
        res.second_reg = rnb;
        res.fwd_a      = {a_ex | a_mem, a_mem};
        res.fwd_b      = {b_ex | b_mem, !b_reg | b_mem};
        res.no_stall   = nost;
        res.alu_code   = {cls.i_load | cls.i_store | shifts | cls.i_bne | cls.i_beq,
                          cls.i_add | cls.i_addi | cls.i_sub | cls.i_subi | shifts,
                          cls.i_sra,
                          cls.i_or | cls.i_ori | cls.i_sub | cls.i_subi | cls.i_store
                              | cls.i_srl | cls.i_sra};
        res.sign_extend = cls.i_andi | cls.i_ori | cls.i_addi | cls.i_subi
                        | cls.i_load | cls.i_store;
        res.write_zero_flag = go && (cls.i_andi | cls.i_ori | cls.i_addi | cls.i_subi
                            | cls.i_and | cls.i_or | cls.i_add | cls.i_sub | shifts);
        res.write_reg = go && (cls.i_add | cls.i_sub | cls.i_and | cls.i_or | shifts
                      | cls.i_addi | cls.i_andi | cls.i_subi | cls.i_ori | cls.i_load);
        res.write_mem  = go && cls.i_store;
        res.mem_to_reg = nost && cls.i_load;
        res.pc_select  = (mem_zero && cls.i_beq) || (!mem_zero && cls.i_bne) || cls.i_br;
    end

endmodule

`default_nettype wire

@@ src/pipeline_cpu_control_unit.sv @@
// top level of the decode control block: input register, decode, output register
// depends on pcu_pkg, pcu_decode, pcu_ctrl, pipeline_cpu_control_unit_assert.svh
//
//   channel | handshake                   | payload
//   --------+-----------------------------+------------------------------------------
//   in      | in_valid / in_stall         | opcode .. ex_pc_taken (decode request)
//   out     | out_valid / out_stall       | is_store .. pc_select (control word)
//
// two register stages: an accepted request goes through the input register, then the
// result register; one request is taken every cycle while out is not stalled
// rst_n clears only the two valid flags, payload registers are not reset
// out_stall holds the result register; the input register drains into it
// whenever it is free, so in_stall rises only when both registers are full
`default_nettype none
`include "pipeline_cpu_control_unit_assert.svh"

module pipeline_cpu_control_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [pcu_pkg::OP_W-1:0]  opcode,
    input  wire logic                      inst_valid,
    input  wire logic [pcu_pkg::REG_W-1:0] src1_reg,
    input  wire logic [pcu_pkg::REG_W-1:0] dest_reg,
    input  wire logic [pcu_pkg::REG_W-1:0] src2_reg,
    input  wire logic [pcu_pkg::REG_W-1:0] ex_dest,
    input  wire logic                      ex_writes_reg,
    input  wire logic                      ex_is_load,
    input  wire logic                      mem_zero,
    input  wire logic [pcu_pkg::REG_W-1:0] mem_dest,
    input  wire logic                      mem_writes_reg,
    input  wire logic                      ex_pc_taken,

    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           is_store,
    output logic [pcu_pkg::REG_W-1:0]      second_reg,
    output logic [1:0]                     fwd_a,
    output logic [1:0]                     fwd_b,
    output logic                           no_stall,
    output logic [3:0]                     alu_code,
    output logic                           sign_extend,
    output logic                           write_zero_flag,
    output logic                           write_reg,
    output logic                           write_mem,
    output logic                           mem_to_reg,
    output logic                           pc_select
);

    // captured request fields
    typedef struct packed {
        logic [pcu_pkg::OP_W-1:0]  opcode;
        logic                      inst_valid;
        logic [pcu_pkg::REG_W-1:0] src1_reg;
        logic [pcu_pkg::REG_W-1:0] dest_reg;
        logic [pcu_pkg::REG_W-1:0] src2_reg;
        logic [pcu_pkg::REG_W-1:0] ex_dest;
        logic                      ex_writes_reg;
        logic                      ex_is_load;
        logic                      mem_zero;
        logic [pcu_pkg::REG_W-1:0] mem_dest;
        logic                      mem_writes_reg;
        logic                      ex_pc_taken;
    } req_t;

    logic             s1_valid_reg, s1_valid_next;
    req_t             s1_reg;
    logic             out_valid_reg, out_valid_next;
    pcu_pkg::result_t out_reg;

    logic             s1_load, s2_load;
    pcu_pkg::class_t  cls;
    pcu_pkg::result_t res;

    // handshake: result register loads when empty or being drained
    assign s2_load  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign s1_load  = in_valid && !in_stall;

    assign s1_valid_next  = s1_load || (s1_valid_reg && !s2_load);
    assign out_valid_next = s2_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg <= '{opcode, inst_valid, src1_reg, dest_reg, src2_reg, ex_dest,
                        ex_writes_reg, ex_is_load, mem_zero, mem_dest,
                        mem_writes_reg, ex_pc_taken};
        end
        if (s2_load)
        begin
            out_reg <= res;
        end
    end

    // decode and control between the two registers
    pcu_decode u_decode (
        .opcode     (s1_reg.opcode),
        .inst_valid (s1_reg.inst_valid),
        .cls        (cls)
    );

    pcu_ctrl u_ctrl (
        .cls            (cls),
        .src1_reg       (s1_reg.src1_reg),
        .dest_reg       (s1_reg.dest_reg),
        .src2_reg       (s1_reg.src2_reg),
        .ex_dest        (s1_reg.ex_dest),
        .ex_writes_reg  (s1_reg.ex_writes_reg),
        .ex_is_load     (s1_reg.ex_is_load),
        .mem_zero       (s1_reg.mem_zero),
        .mem_dest       (s1_reg.mem_dest),
        .mem_writes_reg (s1_reg.mem_writes_reg),
        .ex_pc_taken    (s1_reg.ex_pc_taken),
        .res            (res)
    );

    assign out_valid       = out_valid_reg;
    assign is_store        = out_reg.is_store;
    assign second_reg      = out_reg.second_reg;
    assign fwd_a           = out_reg.fwd_a;
    assign fwd_b           = out_reg.fwd_b;
    assign no_stall        = out_reg.no_stall;
    assign alu_code        = out_reg.alu_code;
    assign sign_extend     = out_reg.sign_extend;
    assign write_zero_flag = out_reg.write_zero_flag;
    assign write_reg       = out_reg.write_reg;
    assign write_mem       = out_reg.write_mem;
    assign mem_to_reg      = out_reg.mem_to_reg;
    assign pc_select       = out_reg.pc_select;

    // accepted request lands in the input register
    `PCU_ASSERT_NXT(a_accept_fills_s1, clk, rst_n, s1_load, s1_valid_reg, "request lost at input")
    // input register moving forward always produces a valid result
    `PCU_ASSERT_NXT(a_s1_fills_out, clk, rst_n, s2_load, out_valid_reg, "request lost at output")
    // gated write enables only without a hazard
    `PCU_ASSERT_IMP(a_writes_need_no_hazard, clk, rst_n,
        out_valid_reg && (out_reg.write_reg || out_reg.write_mem || out_reg.write_zero_flag),
        out_reg.no_stall, "write enable raised during hazard")
    // memory write only for a store
    `PCU_ASSERT_IMP(a_wmem_is_store, clk, rst_n, out_valid_reg && out_reg.write_mem,
        out_reg.is_store, "memory write without store")

endmodule

`default_nettype wire
